// ===== hw/rtl/ess_pkg.sv =====
// ess_pkg: shared types and codes for the elevator stop scheduler.
// No dependencies; imported by elevator_stop_scheduler.
`default_nettype none
package ess_pkg;

  localparam int CarsDef   = 10;
  localparam int QDepthDef = 16;
  localparam int FloorW    = 11;
  localparam int DoorW     = 3;

  typedef logic signed [FloorW-1:0] floor_t;
  typedef logic [DoorW-1:0] door_t;

  typedef enum logic [1:0] {
    MODE_REG  = 2'd0,
    MODE_CALL = 2'd1,
    MODE_STAT = 2'd2,
    MODE_DISC = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KIND_CMD    = 2'd0,
    KIND_ASSIGN = 2'd1,
    KIND_UNAV   = 2'd2
  } kind_e;

  localparam door_t DOOR_CLOSED  = 3'd0;
  localparam door_t DOOR_OPENING = 3'd1;
  localparam door_t DOOR_CLOSING = 3'd3;
  localparam door_t DOOR_BETWEEN = 3'd4;

endpackage
`default_nettype wire

// ===== hw/rtl/ess_ram.sv =====
// ess_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ess_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                       wdata_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output      logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/elevator_stop_scheduler.sv =====
// elevator_stop_scheduler: per-car stop lists and call assignment.
// Depends on ess_pkg and ess_ram (car record RAM, stop list RAM).
//
//  channel   | signals                                   | handshake
//  ----------+-------------------------------------------+--------------------------
//  command   | mode_i car_i ..._floor_i door_code_i      | start_i & !busy_o
//  result    | kind_o car_id_o floor_o last_o            | result_valid_o, one cycle
//
// Register and disconnect complete from the idle state. Status updates the record, and
// also pops the head of a non-empty stop list when the door opens at the heading floor.
// A call examines the cars in turn and makes five list passes for a car (two
// searches, two insert searches with their shifts, one peak pass); the single read
// port of the stop list RAM sets its pace. busy_o is high while a status or call item
// is in progress; register and disconnect never raise it. Results cannot be stalled.
// Reset clears the active marks and the control state; records are written at register.
`default_nettype none
module elevator_stop_scheduler #(
  parameter int CARS        = ess_pkg::CarsDef,
  parameter int QUEUE_DEPTH = ess_pkg::QDepthDef
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  output      logic           busy_o,
  input  wire logic [1:0]     mode_i,
  input  wire logic [3:0]     car_i,
  input  wire ess_pkg::floor_t lowest_floor_i,
  input  wire ess_pkg::floor_t highest_floor_i,
  input  wire ess_pkg::floor_t source_floor_i,
  input  wire ess_pkg::floor_t target_floor_i,
  input  wire ess_pkg::door_t door_code_i,
  input  wire ess_pkg::floor_t at_floor_i,
  input  wire ess_pkg::floor_t heading_floor_i,
  output      logic           result_valid_o,
  output      logic [1:0]     kind_o,
  output      logic [3:0]     car_id_o,
  output      ess_pkg::floor_t floor_o,
  output      logic           last_o
);

  import ess_pkg::*;

  localparam int CW  = (CARS > 1) ? $clog2(CARS) : 1;
  localparam int CCW = $clog2(CARS + 1);
  localparam int NW  = $clog2(QUEUE_DEPTH + 1);
  localparam int LD  = CARS * QUEUE_DEPTH;
  localparam int AW  = $clog2(LD);

  typedef struct packed {
    floor_t        low;
    floor_t        high;
    floor_t        floor;
    floor_t        heading;
    floor_t        peak;
    door_t         door;
    logic [NW-1:0] cnt;
  } rec_t;

  typedef enum logic [3:0] {
    S_IDLE, S_STATUS, S_POP_RD, S_POP_WR, S_CAR_RD, S_CAR_CHK, S_SCAN_RD,
    S_SCAN_DAT, S_SHIFT_RD, S_SHIFT_WR, S_HEAD_RD, S_HEAD_DAT, S_ACK
  } state_e;

  typedef enum logic [2:0] {OP_FIND, OP_ASC, OP_PEAK, OP_DESC, OP_MAX} op_e;

  typedef enum logic [2:0] {
    PH_SRC, PH_SRC_INS, PH_DST, PH_DST_INS, PH_FIN, PH_STAT
  } ph_e;

  state_e        state_q, state_d;
  op_e           op_q, op_d;
  ph_e           ph_q, ph_d;
  logic [CARS-1:0] active_q, active_d;
  logic [CCW-1:0] c_q, c_d;
  rec_t          rec_q, rec_d;
  logic [NW-1:0] idx_q, idx_d, pos_q, pos_d;
  floor_t        prev_q, prev_d, f_q, f_d, src_q, src_d, dst_q, dst_d;
  floor_t        at_q, at_d, hd_q, hd_d;
  door_t         door_q, door_d;
  logic          found_q, found_d, ph2_q, ph2_d, ahead_q, ahead_d, past_q, past_d;
  logic          ov_q, ov_d, last_q, last_d;
  kind_e         kind_q, kind_d;
  logic [3:0]    cid_q, cid_d;
  floor_t        fl_q, fl_d;

  logic          rec_we;
  logic [CW-1:0] rec_waddr, rec_raddr;
  rec_t          rec_wdata, rec_rdata;
  logic          lst_we;
  logic [AW-1:0] lst_waddr, lst_raddr, base;
  floor_t        lst_wdata, lst_rdata;

  logic [31:0]   car_ext, c_ext;
  logic [CW-1:0] ci, c_lo;
  logic          car_in_range;

  assign car_ext      = 32'(car_i);
  assign c_ext        = 32'(c_q);
  assign ci           = car_ext[CW-1:0];
  assign c_lo         = c_ext[CW-1:0];
  assign car_in_range = (car_ext < 32'(CARS));
  assign base         = AW'(c_q) * AW'(QUEUE_DEPTH);

  ess_ram #(.Width($bits(rec_t)), .Depth(CARS)) u_rec_ram (
    .clk_i  (clk_i),
    .we_i   (rec_we),
    .waddr_i(rec_waddr),
    .wdata_i(rec_wdata),
    .raddr_i(rec_raddr),
    .rdata_o(rec_rdata)
  );

  ess_ram #(.Width(FloorW), .Depth(LD)) u_stop_ram (
    .clk_i  (clk_i),
    .we_i   (lst_we),
    .waddr_i(lst_waddr),
    .wdata_i(lst_wdata),
    .raddr_i(lst_raddr),
    .rdata_o(lst_rdata)
  );

  always_comb begin
    rec_t   r;
    floor_t d, eff;
    logic   scan_end, go_next, want_dst, want_fin;
    logic [NW-1:0] pos_v;

    state_d = state_q; op_d = op_q; ph_d = ph_q; active_d = active_q; c_d = c_q;
    rec_d = rec_q; idx_d = idx_q; pos_d = pos_q; prev_d = prev_q; f_d = f_q;
    src_d = src_q; dst_d = dst_q; at_d = at_q; hd_d = hd_q; door_d = door_q;
    found_d = found_q; ph2_d = ph2_q; ahead_d = ahead_q; past_d = past_q;
    ov_d = 1'b0; last_d = 1'b0; kind_d = kind_q; cid_d = cid_q; fl_d = fl_q;
    rec_we = 1'b0; rec_waddr = c_lo; rec_raddr = c_lo;
    lst_we = 1'b0; lst_waddr = base; lst_wdata = f_q; lst_raddr = base;
    r = rec_rdata; d = lst_rdata; eff = rec_rdata.floor;
    scan_end = 1'b0; go_next = 1'b0; want_dst = 1'b0; want_fin = 1'b0;
    pos_v = pos_q;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (mode_i)
            MODE_REG: begin
              if (car_in_range && !active_q[ci]) begin
                active_d[ci] = 1'b1;
                rec_d.low = lowest_floor_i;
                rec_d.high = highest_floor_i;
                rec_d.floor = lowest_floor_i;
                rec_d.heading = lowest_floor_i;
                rec_d.peak = lowest_floor_i;
                rec_d.door = DOOR_CLOSED;
                rec_d.cnt = '0;
                rec_we = 1'b1;
                rec_waddr = ci;
              end
            end
            MODE_DISC: begin
              if (car_in_range) begin
                active_d[ci] = 1'b0;
              end
            end
            MODE_STAT: begin
              if (car_in_range && active_q[ci]) begin
                rec_raddr = ci;
                c_d = CCW'(car_ext);
                at_d = at_floor_i;
                hd_d = heading_floor_i;
                door_d = door_code_i;
                state_d = S_STATUS;
              end
            end
            default: begin
              c_d = '0;
              src_d = source_floor_i;
              dst_d = target_floor_i;
              state_d = S_CAR_RD;
            end
          endcase
        end
      end
      S_STATUS: begin
        r.door = door_q;
        r.floor = at_q;
        r.heading = hd_q;
        rec_d = r;
        if (door_q == DOOR_OPENING && at_q == hd_q && r.cnt != '0) begin
          idx_d = NW'(1);
          state_d = S_POP_RD;
        end else begin
          rec_we = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_POP_RD: begin
        if (idx_q < rec_q.cnt) begin
          lst_raddr = base + AW'(idx_q);
          state_d = S_POP_WR;
        end else begin
          rec_d.cnt = rec_q.cnt - NW'(1);
          if (rec_d.cnt != '0) begin
            op_d = OP_MAX;
            ph_d = PH_STAT;
            idx_d = '0;
            state_d = S_SCAN_RD;
          end else begin
            rec_d.peak = rec_q.floor;
            rec_we = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      S_POP_WR: begin
        lst_we = 1'b1;
        lst_waddr = base + AW'(idx_q) - AW'(1);
        lst_wdata = lst_rdata;
        idx_d = idx_q + NW'(1);
        state_d = S_POP_RD;
      end
      S_CAR_RD: begin
        if (c_q == CCW'(CARS)) begin
          ov_d = 1'b1; last_d = 1'b1; kind_d = KIND_UNAV; cid_d = '0; fl_d = '0;
          state_d = S_IDLE;
        end else if (active_q[c_lo]) begin
          state_d = S_CAR_CHK;
        end else begin
          c_d = c_q + CCW'(1);
        end
      end
      S_CAR_CHK: begin
        if (src_q < r.low || src_q > r.high || dst_q < r.low || dst_q > r.high) begin
          c_d = c_q + CCW'(1);
          state_d = S_CAR_RD;
        end else begin
          eff = (r.door == DOOR_CLOSING || r.door == DOOR_BETWEEN) ? r.heading : r.floor;
          if (r.cnt == '0) begin
            r.peak = eff;
          end
          if (r.heading > r.floor) begin
            ahead_d = (src_q >= eff);
          end else if (r.heading < r.floor) begin
            ahead_d = (src_q <= eff);
          end else begin
            ahead_d = 1'b1;
          end
          past_d = (r.floor >= r.peak);
          rec_d = r;
          ph_d = PH_SRC;
          op_d = OP_FIND;
          f_d = src_q;
          idx_d = '0;
          found_d = 1'b0;
          state_d = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (idx_q < rec_q.cnt) begin
          lst_raddr = base + AW'(idx_q);
          state_d = S_SCAN_DAT;
        end else begin
          scan_end = 1'b1;
          pos_v = rec_q.cnt;
        end
      end
      S_SCAN_DAT: begin
        state_d = S_SCAN_RD;
        case (op_q)
          OP_FIND: begin
            if (d == f_q) begin
              found_d = 1'b1;
              scan_end = 1'b1;
            end else begin
              idx_d = idx_q + NW'(1);
            end
          end
          OP_ASC: begin
            if (!(d < rec_q.peak) || f_q < d) begin
              scan_end = 1'b1;
              pos_v = idx_q;
            end else begin
              idx_d = idx_q + NW'(1);
            end
          end
          OP_PEAK: begin
            // walk the ascending run from the front
            if (idx_q == '0 || d > prev_q) begin
              prev_d = d;
              idx_d = idx_q + NW'(1);
            end else begin
              scan_end = 1'b1;
              pos_v = idx_q;
            end
          end
          OP_DESC: begin
            if (!ph2_q) begin
              if (d == rec_q.peak) begin
                ph2_d = 1'b1;
              end
              idx_d = idx_q + NW'(1);
            end else if (d > f_q) begin
              idx_d = idx_q + NW'(1);
            end else begin
              scan_end = 1'b1;
              pos_v = idx_q;
            end
          end
          default: begin
            if (idx_q == '0 || d > prev_q) begin
              prev_d = d;
            end
            idx_d = idx_q + NW'(1);
          end
        endcase
      end
      S_SHIFT_RD: begin
        if (idx_q > pos_q) begin
          lst_raddr = base + AW'(idx_q) - AW'(1);
          state_d = S_SHIFT_WR;
        end else begin
          lst_we = 1'b1;
          lst_waddr = base + AW'(pos_q);
          lst_wdata = f_q;
          rec_d.cnt = rec_q.cnt + NW'(1);
          if (op_q == OP_PEAK) begin
            rec_d.peak = f_q;
          end
          go_next = 1'b1;
        end
      end
      S_SHIFT_WR: begin
        lst_we = 1'b1;
        lst_waddr = base + AW'(idx_q);
        lst_wdata = lst_rdata;
        idx_d = idx_q - NW'(1);
        state_d = S_SHIFT_RD;
      end
      S_HEAD_RD: begin
        state_d = S_HEAD_DAT;
      end
      S_HEAD_DAT: begin
        if (ph_q == PH_STAT) begin
          ov_d = 1'b1; last_d = 1'b1; kind_d = KIND_CMD; cid_d = c_ext[3:0]; fl_d = d;
          rec_we = 1'b1;
          state_d = S_IDLE;
        end else begin
          if (rec_q.cnt != '0 && (d != rec_q.heading || rec_q.door == DOOR_CLOSED)) begin
            ov_d = 1'b1; kind_d = KIND_CMD; cid_d = c_ext[3:0]; fl_d = d;
          end
          state_d = S_ACK;
        end
      end
      S_ACK: begin
        ov_d = 1'b1; last_d = 1'b1; kind_d = KIND_ASSIGN; cid_d = c_ext[3:0]; fl_d = '0;
        rec_we = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    if (scan_end) begin
      case (op_q)
        OP_FIND: begin
          if (ph_q == PH_SRC) begin
            if (!found_d) begin
              ph_d = PH_SRC_INS;
              idx_d = '0;
              ph2_d = 1'b0;
              if (src_q > rec_q.peak) begin
                op_d = OP_PEAK;
              end else if (ahead_q && !past_q) begin
                op_d = OP_ASC;
              end else begin
                op_d = OP_DESC;
              end
              state_d = S_SCAN_RD;
            end else begin
              want_dst = 1'b1;
            end
          end else if (!found_d) begin
            ph_d = PH_DST_INS;
            op_d = OP_DESC;
            idx_d = '0;
            ph2_d = 1'b0;
            state_d = S_SCAN_RD;
          end else begin
            want_fin = 1'b1;
          end
        end
        OP_MAX: begin
          rec_d.peak = prev_q;
          state_d = S_HEAD_RD;
        end
        default: begin
          pos_d = pos_v;
          if (rec_q.cnt >= NW'(QUEUE_DEPTH)) begin
            go_next = 1'b1;  // full list: insert dropped
          end else begin
            idx_d = rec_q.cnt;
            state_d = S_SHIFT_RD;
          end
        end
      endcase
    end

    if (go_next) begin
      if (ph_q == PH_SRC_INS) begin
        want_dst = 1'b1;
      end else begin
        want_fin = 1'b1;
      end
    end
    if (want_dst) begin
      ph_d = PH_DST;
      op_d = OP_FIND;
      f_d = dst_q;
      idx_d = '0;
      found_d = 1'b0;
      state_d = S_SCAN_RD;
    end
    if (want_fin) begin
      ph_d = PH_FIN;
      if (rec_d.cnt != '0) begin
        op_d = OP_MAX;
        idx_d = '0;
        state_d = S_SCAN_RD;
      end else begin
        state_d = S_HEAD_RD;
      end
    end

    rec_wdata = rec_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      active_q <= '0;
      ov_q <= 1'b0;
      last_q <= 1'b0;
      op_q <= OP_FIND;
      ph_q <= PH_SRC;
      kind_q <= KIND_CMD;
    end else begin
      state_q <= state_d;
      active_q <= active_d;
      ov_q <= ov_d;
      last_q <= last_d;
      op_q <= op_d;
      ph_q <= ph_d;
      kind_q <= kind_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q <= c_d; rec_q <= rec_d; idx_q <= idx_d; pos_q <= pos_d; prev_q <= prev_d;
    f_q <= f_d; src_q <= src_d; dst_q <= dst_d; at_q <= at_d; hd_q <= hd_d;
    door_q <= door_d; found_q <= found_d; ph2_q <= ph2_d; ahead_q <= ahead_d;
    past_q <= past_d; cid_q <= cid_d; fl_q <= fl_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = ov_q;
  assign kind_o         = kind_q;
  assign car_id_o       = cid_q;
  assign floor_o        = fl_q;
  assign last_o         = last_q;

  a_unav_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && kind_q == KIND_UNAV) |-> (last_q && cid_q == '0))
    else $error("unavailable result not final");
  a_ack_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && kind_q == KIND_ASSIGN) |-> last_q)
    else $error("assignment result not final");
  a_more_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !last_q) |=> (ov_q && kind_q == KIND_ASSIGN))
    else $error("non-final beat not followed by assignment");
  a_busy_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !last_q) |-> busy_o)
    else $error("non-final beat while idle");

endmodule
`default_nettype wire
